>>> hdl/assert_macros.svh
// assertion helpers shared by the files that carry concurrent checks
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define DHEC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DHEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/dhec_pkg.sv
// shared constants, command codes and control/status structs
// for the dual hysteresis edge counter; no dependencies
package dhec_pkg;

  // field widths
  localparam int SAMPLE_BITS = 10;
  localparam int COUNT_BITS  = 32;
  localparam int PCT_BITS    = 7;
  localparam int CMD_BITS    = 3;

  // division datapath widths: numerator magnitude stays below 3 * 100 * 2^SAMPLE_BITS
  localparam int NUM_W  = SAMPLE_BITS + 9;
  localparam int PROD_W = NUM_W + 1;
  localparam int SUM_W  = NUM_W + 2;
  localparam int DIV_W  = PCT_BITS + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  // job sequencing: two channels times upper and lower bound
  localparam int JOB_W = 2;
  localparam logic [JOB_W-1:0] JOB_LAST = '1;

  // stream word layout
  localparam int IN_FIELDS_W  = 2 * SAMPLE_BITS + 2 * COUNT_BITS;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * COUNT_BITS + 2 + 4 * SAMPLE_BITS + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int USER_W       = ((CMD_BITS + 7) / 8) * 8;

  // constants
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [PCT_BITS-1:0]    PCT_RESET  = PCT_BITS'(10);
  localparam logic [PCT_BITS-1:0]    PCT_ONE    = PCT_BITS'(1);
  localparam logic [PCT_BITS-1:0]    PCT_FULL   = PCT_BITS'(100);
  localparam logic [DIV_W-1:0]       FINISH_DIV = DIV_W'(200);

  // command codes
  typedef enum logic [CMD_BITS-1:0] {
    CMD_TRACK      = 3'd0,
    CMD_CAL_START  = 3'd1,
    CMD_CAL_SAMPLE = 3'd2,
    CMD_CAL_FINISH = 3'd3,
    CMD_LOAD       = 3'd4
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic track;
    logic seed;
    logic sample;
    logic load;
    logic prep;
    logic start;
    logic store;
    logic is_finish;
    logic job_ch;
    logic job_lo;
    logic set_cal;
  } dp_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic cal_done;
    logic div_done;
  } dp_status_t;

endpackage

>>> hdl/dhec_div.sv
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on dhec_pkg for widths
module dhec_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dhec_pkg::NUM_W-1:0]  dividend_i,
  input  logic [dhec_pkg::DIV_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [dhec_pkg::NUM_W-1:0]  quotient_o
);
  import dhec_pkg::*;

  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dvs_q;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    trial_sub;
  logic              fits;

  // one shift-subtract step
  always_comb begin
    trial     = {rem_q, quo_q[NUM_W-1]};
    trial_sub = trial - {1'b0, dvs_q};
    fits      = trial >= {1'b0, dvs_q};
  end

  // step sequencing
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = DCNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hdl/dhec_datapath.sv
// channel state, comparators, calibration arithmetic and the dead band register
// depends on dhec_pkg and dhec_div
module dhec_datapath (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [dhec_pkg::PCT_BITS-1:0]              cfg_wdata_i,
  input  logic [1:0][dhec_pkg::SAMPLE_BITS-1:0]      sample_i,
  input  logic [1:0][dhec_pkg::COUNT_BITS-1:0]       count_load_i,
  input  dhec_pkg::dp_ctrl_t                         ctrl_i,
  output dhec_pkg::dp_status_t                       status_o,
  output logic [1:0][dhec_pkg::COUNT_BITS-1:0]       count_o,
  output logic [1:0]                                 level_o,
  output logic [1:0][dhec_pkg::SAMPLE_BITS-1:0]      upper_o,
  output logic [1:0][dhec_pkg::SAMPLE_BITS-1:0]      lower_o,
  output logic                                       cal_done_o
);
  import dhec_pkg::*;

  logic [PCT_BITS-1:0]              pct_q;
  logic [PCT_BITS-1:0]              p_eff;
  logic [1:0]                       level_q, level_d;
  logic [1:0][COUNT_BITS-1:0]       count_q, count_d;
  logic [1:0][SAMPLE_BITS-1:0]      upper_q, upper_d;
  logic [1:0][SAMPLE_BITS-1:0]      lower_q, lower_d;
  logic [1:0][SAMPLE_BITS-1:0]      smax_q, smax_d;
  logic [1:0][SAMPLE_BITS-1:0]      smin_q, smin_d;
  logic                             cal_q, cal_d;

  logic [SAMPLE_BITS-1:0]           op_x, op_y;
  logic [SAMPLE_BITS:0]             op_sum;
  logic signed [SAMPLE_BITS:0]      op_dif;
  logic [PCT_BITS-1:0]              fac_u, fac_s;
  logic [NUM_W-1:0]                 a_d, a_q;
  logic signed [PROD_W-1:0]         b_d, b_q;
  logic [DIV_W-1:0]                 dvs_d, dvs_q;
  logic signed [SUM_W-1:0]          a_ext, b_ext, num;
  logic                             neg_q;
  logic                             div_done;
  logic [NUM_W-1:0]                 quo;
  logic [SAMPLE_BITS-1:0]           res;

  // dead band register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= PCT_RESET;
    end else if (cfg_we_i) begin
      pct_q <= cfg_wdata_i;
    end
  end

  // effective percent, zero acts as one and large values saturate
  always_comb begin
    if (pct_q == '0) begin
      p_eff = PCT_ONE;
    end else if (pct_q > PCT_FULL) begin
      p_eff = PCT_FULL;
    end else begin
      p_eff = pct_q;
    end
  end

  // operand products for the current job; finish uses the span, start the thresholds
  always_comb begin
    op_x   = ctrl_i.is_finish ? smax_q[ctrl_i.job_ch] : upper_q[ctrl_i.job_ch];
    op_y   = ctrl_i.is_finish ? smin_q[ctrl_i.job_ch] : lower_q[ctrl_i.job_ch];
    op_sum = {1'b0, op_x} + {1'b0, op_y};
    op_dif = $signed({1'b0, op_x}) - $signed({1'b0, op_y});
    fac_u  = ctrl_i.is_finish ? PCT_FULL : p_eff;
    fac_s  = ctrl_i.is_finish ? p_eff : PCT_FULL;
    a_d    = NUM_W'(fac_u) * NUM_W'(op_sum);
    b_d    = PROD_W'(op_dif) * PROD_W'($signed({1'b0, fac_s}));
    dvs_d  = ctrl_i.is_finish ? FINISH_DIV : {p_eff, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prep) begin
      a_q   <= a_d;
      b_q   <= b_d;
      dvs_q <= dvs_d;
    end
  end

  // numerator: upper bound adds the band term, lower bound subtracts it
  always_comb begin
    a_ext = $signed(SUM_W'(a_q));
    b_ext = SUM_W'(b_q);
    num   = ctrl_i.job_lo ? (a_ext - b_ext) : (a_ext + b_ext);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      neg_q <= num[SUM_W-1];
    end
  end

  dhec_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.start),
    .dividend_i (num[NUM_W-1:0]),
    .divisor_i  (dvs_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // negative numerators give zero, large quotients clamp to full scale
  always_comb begin
    if (neg_q) begin
      res = '0;
    end else if (quo > NUM_W'(SAMPLE_MAX)) begin
      res = SAMPLE_MAX;
    end else begin
      res = quo[SAMPLE_BITS-1:0];
    end
  end

  // next channel state
  always_comb begin
    level_d = level_q;
    count_d = count_q;
    upper_d = upper_q;
    lower_d = lower_q;
    smax_d  = smax_q;
    smin_d  = smin_q;
    cal_d   = cal_q;
    for (int ch = 0; ch < 2; ch++) begin
      // schmitt comparator, count both crossings
      if (ctrl_i.track) begin
        if (sample_i[ch] > upper_q[ch] && !level_q[ch]) begin
          level_d[ch] = 1'b1;
          count_d[ch] = count_q[ch] + COUNT_BITS'(1);
        end else if (sample_i[ch] < lower_q[ch] && level_q[ch]) begin
          level_d[ch] = 1'b0;
          count_d[ch] = count_q[ch] + COUNT_BITS'(1);
        end
      end
      // fresh window
      if (ctrl_i.seed) begin
        smax_d[ch] = '0;
        smin_d[ch] = SAMPLE_MAX;
      end
      // span tracking
      if (ctrl_i.sample) begin
        if (sample_i[ch] > smax_q[ch]) begin
          smax_d[ch] = sample_i[ch];
        end
        if (sample_i[ch] < smin_q[ch]) begin
          smin_d[ch] = sample_i[ch];
        end
      end
      if (ctrl_i.load) begin
        count_d[ch] = count_load_i[ch];
      end
    end
    // divider result write-back
    if (ctrl_i.store) begin
      if (ctrl_i.is_finish) begin
        if (ctrl_i.job_lo) begin
          lower_d[ctrl_i.job_ch] = res;
        end else begin
          upper_d[ctrl_i.job_ch] = res;
        end
      end else begin
        if (ctrl_i.job_lo) begin
          smin_d[ctrl_i.job_ch] = res;
        end else begin
          smax_d[ctrl_i.job_ch] = res;
        end
      end
    end
    if (ctrl_i.set_cal) begin
      cal_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      count_q <= '0;
      upper_q <= {2{SAMPLE_MID}};
      lower_q <= {2{SAMPLE_MID}};
      smax_q  <= '0;
      smin_q  <= {2{SAMPLE_MAX}};
      cal_q   <= 1'b0;
    end else begin
      level_q <= level_d;
      count_q <= count_d;
      upper_q <= upper_d;
      lower_q <= lower_d;
      smax_q  <= smax_d;
      smin_q  <= smin_d;
      cal_q   <= cal_d;
    end
  end

  assign status_o.cal_done = cal_q;
  assign status_o.div_done = div_done;
  assign count_o           = count_q;
  assign level_o           = level_q;
  assign upper_o           = upper_q;
  assign lower_o           = lower_q;
  assign cal_done_o        = cal_q;

endmodule

>>> hdl/dhec_ctrl.sv
// command decode, handshakes and the calibration job sequencer
// depends on dhec_pkg
module dhec_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [dhec_pkg::CMD_BITS-1:0]  cmd_i,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  input  dhec_pkg::dp_status_t           status_i,
  output dhec_pkg::dp_ctrl_t             ctrl_o
);
  import dhec_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PREP  = 4'b0010,
    ST_START = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [JOB_W-1:0] job_q, job_d;
  logic             finish_q, finish_d;
  logic             m_valid_q, m_valid_d;
  cmd_e             cmd;
  logic             accept;
  logic             long_op;
  logic             store;
  logic             last_store;

  // decode
  always_comb begin
    cmd       = cmd_e'(cmd_i);
    s_ready_o = (state_q == ST_IDLE) && (!m_valid_q || m_ready_i);
    accept    = s_valid_i && s_ready_o;
    long_op   = (cmd == CMD_CAL_FINISH) || (cmd == CMD_CAL_START && status_i.cal_done);
    store     = (state_q == ST_WAIT) && status_i.div_done;
    last_store = store && (job_q == JOB_LAST);
  end

  // job sequencer
  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    finish_d = finish_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && long_op) begin
          state_d  = ST_PREP;
          job_d    = '0;
          finish_d = (cmd == CMD_CAL_FINISH);
        end
      end
      ST_PREP:  state_d = ST_START;
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (status_i.div_done) begin
          if (job_q == JOB_LAST) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_PREP;
            job_d   = job_q + JOB_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result word valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (m_valid_q && m_ready_i) begin
      m_valid_d = 1'b0;
    end
    if ((accept && !long_op) || last_store) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      job_q     <= '0;
      finish_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      job_q     <= job_d;
      finish_q  <= finish_d;
      m_valid_q <= m_valid_d;
    end
  end

  // datapath commands
  always_comb begin
    ctrl_o.track     = accept && (cmd == CMD_TRACK);
    ctrl_o.seed      = accept && (cmd == CMD_CAL_START) && !status_i.cal_done;
    ctrl_o.sample    = accept && (cmd == CMD_CAL_SAMPLE);
    ctrl_o.load      = accept && (cmd == CMD_LOAD);
    ctrl_o.prep      = (state_q == ST_PREP);
    ctrl_o.start     = (state_q == ST_START);
    ctrl_o.store     = store;
    ctrl_o.is_finish = finish_q;
    ctrl_o.job_ch    = job_q[1];
    ctrl_o.job_lo    = job_q[0];
    ctrl_o.set_cal   = last_store && finish_q;
  end

  assign m_valid_o = m_valid_q;

endmodule

>>> hdl/dual_hysteresis_edge_counter.sv
// dual hysteresis edge counter, top level; uses dhec_pkg, dhec_ctrl, dhec_datapath
// track, cal sample, load, unused codes and a first cal start: word valid next cycle
// cal finish and cal start once calibrated: a prep, start and wait sequence on the
//   shared one-bit-per-cycle divider, run once per channel and bound; one word at a time
// reset clears counters and levels, thresholds to mid-scale, span to empty, dead band 10
`include "assert_macros.svh"

module dual_hysteresis_edge_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dhec_pkg::PCT_BITS-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // left_sample, right_sample, left_count_load, right_count_load
  input  logic [dhec_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // cmd
  input  logic [dhec_pkg::USER_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_count, right_count, left_level, right_level, left_high_thr, left_low_thr,
  // right_high_thr, right_low_thr, calibrated
  output logic [dhec_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import dhec_pkg::*;

  dp_ctrl_t                    dp_ctrl;
  dp_status_t                  dp_status;
  logic [1:0][SAMPLE_BITS-1:0] sample;
  logic [1:0][COUNT_BITS-1:0]  count_load;
  logic [1:0][COUNT_BITS-1:0]  count;
  logic [1:0]                  level;
  logic [1:0][SAMPLE_BITS-1:0] upper;
  logic [1:0][SAMPLE_BITS-1:0] lower;
  logic                        cal_done;

  // unpack input word
  assign sample[0]     = s_axis_tdata[SAMPLE_BITS-1:0];
  assign sample[1]     = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign count_load[0] = s_axis_tdata[2*SAMPLE_BITS+COUNT_BITS-1:2*SAMPLE_BITS];
  assign count_load[1] = s_axis_tdata[2*SAMPLE_BITS+2*COUNT_BITS-1:2*SAMPLE_BITS+COUNT_BITS];

  dhec_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .cmd_i     (s_axis_tuser[CMD_BITS-1:0]),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (dp_status),
    .ctrl_o    (dp_ctrl)
  );

  dhec_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (sample),
    .count_load_i (count_load),
    .ctrl_i       (dp_ctrl),
    .status_o     (dp_status),
    .count_o      (count),
    .level_o      (level),
    .upper_o      (upper),
    .lower_o      (lower),
    .cal_done_o   (cal_done)
  );

  // pack result word, state registers hold until the next accepted word
  assign m_axis_tdata = OUT_DATA_W'({cal_done, lower[1], upper[1], lower[0], upper[0],
                                     level[1], level[0], count[1], count[0]});

  // checks
  `DHEC_ASSERT_IMPL(a_no_overrun, s_axis_tvalid && s_axis_tready, !m_axis_tvalid || m_axis_tready, "input taken while result word still pending")
  `DHEC_ASSERT_NEXT(a_busy_blocks, dp_ctrl.start, !s_axis_tready, "input ready during a division")
  `DHEC_ASSERT_IMPL(a_thr_on_finish, !$stable({upper, lower}), $past(dp_ctrl.store && dp_ctrl.is_finish), "thresholds changed outside cal finish")

endmodule
